### rtl/matrix_line_sums_top_macros.svh
`ifndef MATRIX_LINE_SUMS_TOP_MACROS_SVH
`define MATRIX_LINE_SUMS_TOP_MACROS_SVH

// same-cycle implication, checked outside reset
`define MLS_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define MLS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/mls_pkg.sv
package mls_pkg;

  localparam int MAX_SIZE_DEF     = 16;
  localparam int ELEMENT_BITS_DEF = 16;
  localparam int SUM_W            = 20;
  localparam int SIZE_W           = 5;
  localparam int IDX_W            = 4;
  localparam int KIND_W           = 2;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 5'd4;

  typedef enum logic [KIND_W-1:0] {
    KIND_ROW  = 2'd0,
    KIND_COL  = 2'd1,
    KIND_MAIN = 2'd2,
    KIND_ANTI = 2'd3
  } mls_kind_t;

  typedef enum logic [1:0] {
    ST_ACC,
    ST_COL,
    ST_MAIN,
    ST_ANTI
  } mls_state_t;

  typedef struct packed {
    logic add_en;
    logic shift_en;
    logic clear;
  } mls_cell_ctrl_t;

endpackage

### rtl/mls_in_if.sv
interface mls_in_if #(
  parameter int ELEMENT_BITS = mls_pkg::ELEMENT_BITS_DEF
);
  logic                           valid;
  logic                           ready;
  logic signed [ELEMENT_BITS-1:0] element;

  modport source (output valid, output element, input ready);
  modport sink   (input valid, input element, output ready);
  modport mon    (input valid, input element, input ready);
endinterface

### rtl/mls_out_if.sv
interface mls_out_if;
  import mls_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [KIND_W-1:0]       kind;
  logic [IDX_W-1:0]        line_index;
  logic signed [SUM_W-1:0] total;
  logic                    last;

  modport source (output valid, output kind, output line_index, output total,
                  output last, input ready);
  modport sink   (input valid, input kind, input line_index, input total,
                  input last, output ready);
  modport mon    (input valid, input kind, input line_index, input total,
                  input last, input ready);
endinterface

### rtl/mls_cell.sv
module mls_cell #(
  parameter int POS_W = 4,
  parameter int IDX   = 0
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  mls_pkg::mls_cell_ctrl_t       ctrl,
  input  logic [POS_W-1:0]              col,
  input  logic [mls_pkg::SUM_W-1:0]     addend,
  input  logic [mls_pkg::SUM_W-1:0]     shift_in,
  output logic [mls_pkg::SUM_W-1:0]     acc
);
  import mls_pkg::*;

  logic [SUM_W-1:0] acc_r;
  logic [SUM_W-1:0] acc_nxt;
  logic             hit;

  assign hit = (col == POS_W'(IDX));

  always_comb begin
    acc_nxt = acc_r;
    if (ctrl.clear) begin
      acc_nxt = '0;
    end else if (ctrl.shift_en) begin
      acc_nxt = shift_in;
    end else if (ctrl.add_en && hit) begin
      acc_nxt = acc_r + addend;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else begin
      acc_r <= acc_nxt;
    end
  end

  assign acc = acc_r;
endmodule

### rtl/mls_chain.sv
module mls_chain #(
  parameter int MAX_SIZE = mls_pkg::MAX_SIZE_DEF,
  parameter int POS_W    = 4
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  mls_pkg::mls_cell_ctrl_t   ctrl,
  input  logic [POS_W-1:0]          col,
  input  logic [mls_pkg::SUM_W-1:0] addend,
  output logic [mls_pkg::SUM_W-1:0] head
);
  import mls_pkg::*;

  logic [SUM_W-1:0] acc_w [MAX_SIZE];
  logic [SUM_W-1:0] link_w [MAX_SIZE];

  // each cell passes its sum toward the head while draining, zero enters at the tail
  for (genvar j = 0; j < MAX_SIZE; j++) begin : g_cell
    if (j == MAX_SIZE - 1) begin : g_tail
      assign link_w[j] = '0;
    end else begin : g_mid
      assign link_w[j] = acc_w[j+1];
    end

    mls_cell #(
      .POS_W (POS_W),
      .IDX   (j)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctrl     (ctrl),
      .col      (col),
      .addend   (addend),
      .shift_in (link_w[j]),
      .acc      (acc_w[j])
    );
  end

  assign head = acc_w[0];
endmodule

### rtl/matrix_line_sums_top.sv
// Streaming row, column and diagonal sums of an n by n signed matrix given in
// row-major order, one element per item, n taken from cfg_wdata (0 acts as 1,
// values above MAX_SIZE act as MAX_SIZE). While the result register is free an
// element is taken every cycle, and the end of a row costs nothing extra. After
// the last element of a matrix the input is held off while the column
// accumulators, a chain of MAX_SIZE cells, shift their sums out through the
// single result register, one per cycle while it is free, followed by the
// main and the anti diagonal sums. A stalled result holds off the input until
// it is taken.
module matrix_line_sums_top #(
  parameter int MAX_SIZE = mls_pkg::MAX_SIZE_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [mls_pkg::SIZE_W-1:0] cfg_wdata,
  mls_in_if.sink                     in_chan,
  mls_out_if.source                  out_chan
);
  import mls_pkg::*;

  localparam int POS_W = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
  localparam int N_W   = $clog2(MAX_SIZE + 1);
  localparam int CMP_W = N_W + 1;

  logic [SIZE_W-1:0] cfg_size_r;
  mls_state_t        state_r, state_nxt;
  logic [POS_W-1:0]  r_r, r_nxt;
  logic [POS_W-1:0]  c_r, c_nxt;
  logic [POS_W-1:0]  drain_r, drain_nxt;
  logic [SUM_W-1:0]  row_acc_r, row_acc_nxt;
  logic [SUM_W-1:0]  main_r, main_nxt;
  logic [SUM_W-1:0]  anti_r, anti_nxt;

  logic              out_valid_r, out_valid_nxt;
  mls_kind_t         out_kind_r;
  logic [IDX_W-1:0]  out_idx_r;
  logic [SUM_W-1:0]  out_total_r;
  logic              out_last_r;

  logic              load;
  mls_kind_t         ld_kind;
  logic [IDX_W-1:0]  ld_idx;
  logic [SUM_W-1:0]  ld_total;
  logic              ld_last;

  logic [N_W-1:0]    n;
  logic [CMP_W-1:0]  n_ext, r_ext, c_ext, d_ext;
  logic [31:0]       e32, r32, d32;
  logic [SUM_W-1:0]  e_sum;
  logic [SUM_W-1:0]  row_sum;
  logic              slot_free, acc_fire;
  logic              row_end, mat_end, main_hit, anti_hit, col_live;
  logic [SUM_W-1:0]  head;
  mls_cell_ctrl_t    cell_ctrl;

  // effective size
  always_comb begin
    if (cfg_size_r == '0) begin
      n = N_W'(1);
    end else if (32'(cfg_size_r) > 32'(MAX_SIZE)) begin
      n = N_W'(MAX_SIZE);
    end else begin
      n = N_W'(cfg_size_r);
    end
  end

  assign n_ext = CMP_W'(n);
  assign r_ext = CMP_W'(r_r);
  assign c_ext = CMP_W'(c_r);
  assign d_ext = CMP_W'(drain_r);

  assign e32   = 32'(in_chan.element);
  assign e_sum = e32[SUM_W-1:0];
  assign r32   = 32'(r_r);
  assign d32   = 32'(drain_r);

  assign row_sum  = row_acc_r + e_sum;
  assign row_end  = (c_ext + CMP_W'(1)) >= n_ext;
  assign mat_end  = (r_ext + CMP_W'(1)) >= n_ext;
  assign main_hit = (r_r == c_r);
  assign anti_hit = (r_ext + c_ext) == (n_ext - CMP_W'(1));
  assign col_live = c_ext < n_ext;

  assign slot_free = !out_valid_r || out_chan.ready;
  assign acc_fire  = in_chan.valid && in_chan.ready;
  assign in_chan.ready = (state_r == ST_ACC) && slot_free;

  assign cell_ctrl.add_en   = acc_fire && col_live;
  assign cell_ctrl.shift_en = (state_r == ST_COL) && slot_free;
  assign cell_ctrl.clear    = (state_r == ST_ANTI) && slot_free;

  mls_chain #(
    .MAX_SIZE (MAX_SIZE),
    .POS_W    (POS_W)
  ) u_chain (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctrl   (cell_ctrl),
    .col    (c_r),
    .addend (e_sum),
    .head   (head)
  );

  always_comb begin
    state_nxt   = state_r;
    r_nxt       = r_r;
    c_nxt       = c_r;
    drain_nxt   = drain_r;
    row_acc_nxt = row_acc_r;
    main_nxt    = main_r;
    anti_nxt    = anti_r;
    load        = 1'b0;
    ld_kind     = KIND_ROW;
    ld_idx      = '0;
    ld_total    = '0;
    ld_last     = 1'b0;
    case (state_r)
      ST_ACC: begin
        if (acc_fire) begin
          row_acc_nxt = row_sum;
          if (main_hit) begin
            main_nxt = main_r + e_sum;
          end
          if (anti_hit) begin
            anti_nxt = anti_r + e_sum;
          end
          if (!row_end) begin
            c_nxt = c_r + 1'b1;
          end else begin
            load        = 1'b1;
            ld_kind     = KIND_ROW;
            ld_idx      = r32[IDX_W-1:0];
            ld_total    = row_sum;
            row_acc_nxt = '0;
            c_nxt       = '0;
            if (!mat_end) begin
              r_nxt = r_r + 1'b1;
            end else begin
              r_nxt     = '0;
              drain_nxt = '0;
              state_nxt = ST_COL;
            end
          end
        end
      end
      ST_COL: begin
        if (slot_free) begin
          load      = 1'b1;
          ld_kind   = KIND_COL;
          ld_idx    = d32[IDX_W-1:0];
          ld_total  = head;
          drain_nxt = drain_r + 1'b1;
          if ((d_ext + CMP_W'(1)) >= n_ext) begin
            state_nxt = ST_MAIN;
          end
        end
      end
      ST_MAIN: begin
        if (slot_free) begin
          load      = 1'b1;
          ld_kind   = KIND_MAIN;
          ld_total  = main_r;
          state_nxt = ST_ANTI;
        end
      end
      ST_ANTI: begin
        if (slot_free) begin
          load      = 1'b1;
          ld_kind   = KIND_ANTI;
          ld_total  = anti_r;
          ld_last   = 1'b1;
          main_nxt  = '0;
          anti_nxt  = '0;
          state_nxt = ST_ACC;
        end
      end
      default: begin
        state_nxt = ST_ACC;
      end
    endcase
  end

  always_comb begin
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_size_r  <= SIZE_RESET;
      state_r     <= ST_ACC;
      r_r         <= '0;
      c_r         <= '0;
      drain_r     <= '0;
      row_acc_r   <= '0;
      main_r      <= '0;
      anti_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        cfg_size_r <= cfg_wdata;
      end
      state_r     <= state_nxt;
      r_r         <= r_nxt;
      c_r         <= c_nxt;
      drain_r     <= drain_nxt;
      row_acc_r   <= row_acc_nxt;
      main_r      <= main_nxt;
      anti_r      <= anti_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_kind_r  <= ld_kind;
      out_idx_r   <= ld_idx;
      out_total_r <= ld_total;
      out_last_r  <= ld_last;
    end
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.kind       = out_kind_r;
  assign out_chan.line_index = out_idx_r;
  assign out_chan.total      = out_total_r;
  assign out_chan.last       = out_last_r;
endmodule

### rtl/mls_checker.sv
`include "matrix_line_sums_top_macros.svh"

module mls_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [mls_pkg::KIND_W-1:0] out_kind,
  input logic [mls_pkg::IDX_W-1:0]  out_line_index,
  input logic [mls_pkg::SUM_W-1:0]  out_total,
  input logic                       out_last
);
  import mls_pkg::*;

  // a result waiting in the slot keeps its fields
  `MLS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_kind) && $stable(out_line_index) && $stable(out_total) && $stable(out_last), "result changed while stalled")

  // last marks exactly the anti diagonal sum
  `MLS_ASSERT_SAME(a_last_anti, out_valid, out_last == (out_kind == KIND_ANTI), "last flag does not match anti diagonal")

  // diagonal sums carry index zero
  `MLS_ASSERT_SAME(a_diag_idx, out_valid && (out_kind == KIND_MAIN || out_kind == KIND_ANTI), out_line_index == '0, "diagonal result with nonzero index")

  // the anti diagonal follows the main diagonal at once
  `MLS_ASSERT_NEXT(a_main_then_anti, out_valid && out_ready && out_kind == KIND_MAIN, out_valid && out_kind == KIND_ANTI, "anti diagonal did not follow main")

  // no item taken while a result is stuck in the slot
  `MLS_ASSERT_SAME(a_ready_slot, in_ready, !out_valid || out_ready, "input taken with result slot blocked")

  // in_valid is part of the handshake but no property needs it on its own
  logic unused_in_valid;
  assign unused_in_valid = in_valid;
endmodule

bind matrix_line_sums_top mls_checker u_mls_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_chan.valid),
  .in_ready       (in_chan.ready),
  .out_valid      (out_chan.valid),
  .out_ready      (out_chan.ready),
  .out_kind       (out_chan.kind),
  .out_line_index (out_chan.line_index),
  .out_total      (out_chan.total),
  .out_last       (out_chan.last)
);

### test/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mls_pkg::*;

  localparam int EW           = ELEMENT_BITS_DEF;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int RANDOM_ITEMS = 20;

  typedef struct packed {
    mls_kind_t               kind;
    logic [IDX_W-1:0]        line_index;
    logic signed [SUM_W-1:0] total;
    logic                    last;
  } line_sum_t;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              cfg_we;
  logic [SIZE_W-1:0] cfg_wdata;

  mls_in_if  in_chan ();
  mls_out_if out_chan ();

  matrix_line_sums_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_chan   (in_chan),
    .out_chan  (out_chan)
  );

  always #10 clk = ~clk;

  logic signed [EW-1:0] pending_elements[$];
  line_sum_t            sums_due[$];
  line_sum_t            want;

  logic idle_on;
  logic want_long_hold;
  logic long_hold_done;
  int   gap_left;
  int   stall_left;
  int   hold_left;

  int failures;
  int elements_in;
  int results_seen;
  int size_writes;
  int cycle_count;

  // predictor copy of the block state
  logic [SIZE_W-1:0]       size_reg;
  int unsigned             row_at;
  int unsigned             col_at;
  logic signed [SUM_W-1:0] row_run;
  logic signed [SUM_W-1:0] main_run;
  logic signed [SUM_W-1:0] anti_run;
  logic signed [SUM_W-1:0] col_run [MAX_SIZE_DEF];

  function automatic int unsigned eff_size(input logic [SIZE_W-1:0] v);
    if (v == 0) return 1;
    if (v > MAX_SIZE_DEF) return MAX_SIZE_DEF;
    return v;
  endfunction

  task automatic clear_sums();
    row_at   = 0;
    col_at   = 0;
    row_run  = '0;
    main_run = '0;
    anti_run = '0;
    foreach (col_run[j]) col_run[j] = '0;
  endtask

  task automatic absorb_element(input logic signed [EW-1:0] e);
    int unsigned             n;
    logic signed [SUM_W-1:0] ext;
    n   = eff_size(size_reg);
    ext = e;
    row_run = row_run + ext;
    if (col_at < n) col_run[col_at] = col_run[col_at] + ext;
    if (row_at == col_at) main_run = main_run + ext;
    if (row_at + col_at == n - 1) anti_run = anti_run + ext;
    if (col_at + 1 < n) begin
      col_at = col_at + 1;
    end else begin
      sums_due.push_back('{KIND_ROW, IDX_W'(row_at), row_run, 1'b0});
      row_run = '0;
      col_at  = 0;
      if (row_at + 1 < n) begin
        row_at = row_at + 1;
      end else begin
        for (int unsigned j = 0; j < n; j++)
          sums_due.push_back('{KIND_COL, IDX_W'(j), col_run[j], 1'b0});
        sums_due.push_back('{KIND_MAIN, IDX_W'(0), main_run, 1'b0});
        sums_due.push_back('{KIND_ANTI, IDX_W'(0), anti_run, 1'b1});
        clear_sums();
      end
    end
  endtask

  // elements still needed to close the matrix now in progress
  function automatic int items_to_finish();
    int unsigned n;
    int unsigned r;
    int unsigned c;
    int          k;
    n = eff_size(size_reg);
    r = row_at;
    c = col_at;
    k = 0;
    while (1) begin
      k++;
      if (c + 1 < n) c++;
      else if (r + 1 < n) begin
        r++;
        c = 0;
      end else break;
    end
    return k;
  endfunction

  function automatic logic signed [EW-1:0] pick_element();
    case ($urandom_range(0, 7))
      0: return {1'b0, {(EW-1){1'b1}}};
      1: return {1'b1, {(EW-1){1'b0}}};
      2: return EW'(int'($urandom_range(0, 16)) - 8);
      default: return EW'($urandom);
    endcase
  endfunction

  task automatic queue_elements(input int count);
    repeat (count) pending_elements.push_back(pick_element());
  endtask

  task automatic set_size(input logic [SIZE_W-1:0] v);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we   <= 1'b0;
    size_reg = v;
    size_writes++;
  endtask

  // wait for the sender to empty and every line sum to come back
  task automatic settle();
    do @(negedge clk);
    while (pending_elements.size() != 0 || in_chan.valid || sums_due.size() != 0);
    repeat (8) @(posedge clk);
  endtask

  // element sender
  always @(posedge clk) begin
    if (!rst_n) begin
      in_chan.valid   <= 1'b0;
      in_chan.element <= '0;
      gap_left        <= 0;
    end else if (!in_chan.valid || in_chan.ready) begin
      if (idle_on && gap_left > 0) begin
        in_chan.valid <= 1'b0;
        gap_left      <= gap_left - 1;
      end else if (pending_elements.size() != 0) begin
        in_chan.valid   <= 1'b1;
        in_chan.element <= pending_elements.pop_front();
        if (idle_on && $urandom_range(0, 4) == 0) gap_left <= $urandom_range(1, 13);
        else gap_left <= 0;
      end else begin
        in_chan.valid <= 1'b0;
      end
    end
  end

  // result receiver, with one long hold-off to back the block up
  always @(posedge clk) begin
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
      stall_left     <= 0;
      hold_left      <= 0;
      long_hold_done <= 1'b0;
    end else if (want_long_hold && !long_hold_done) begin
      out_chan.ready <= 1'b0;
      hold_left      <= 299;
      long_hold_done <= 1'b1;
    end else if (hold_left > 0) begin
      out_chan.ready <= 1'b0;
      hold_left      <= hold_left - 1;
    end else if (idle_on && stall_left > 0) begin
      out_chan.ready <= 1'b0;
      stall_left     <= stall_left - 1;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      out_chan.ready <= 1'b0;
      stall_left     <= $urandom_range(0, 12);
    end else begin
      out_chan.ready <= 1'b1;
      stall_left     <= 0;
    end
  end

  // prediction on each accepted item, then checking of each accepted result
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_chan.valid && in_chan.ready) begin
        absorb_element(in_chan.element);
        elements_in++;
      end
      if (out_chan.valid && out_chan.ready) begin
        if (sums_due.size() == 0) begin
          $error("unexpected result: kind %0d line_index %0d total %0d last %0d",
                 out_chan.kind, out_chan.line_index, out_chan.total, out_chan.last);
          failures++;
        end else begin
          want = sums_due.pop_front();
          results_seen++;
          if (out_chan.kind !== want.kind) begin
            $error("kind: expected %0d, got %0d", want.kind, out_chan.kind);
            failures++;
          end
          if (out_chan.line_index !== want.line_index) begin
            $error("line_index: expected %0d, got %0d", want.line_index, out_chan.line_index);
            failures++;
          end
          if (out_chan.total !== want.total) begin
            $error("total: expected %0d, got %0d", want.total, out_chan.total);
            failures++;
          end
          if (out_chan.last !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, out_chan.last);
            failures++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d line sums outstanding",
               cycle_count, sums_due.size());
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    int sz;
    int n;
    int cnt;
    int small_items;
    rst_n           <= 1'b0;
    cfg_we          <= 1'b0;
    cfg_wdata       <= '0;
    want_long_hold  <= 1'b0;
    idle_on     = 1'b1;
    size_reg    = SIZE_RESET;
    small_items = 0;
    clear_sums();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // reset size of 4: full rows of the extremes, then mixed bit patterns
    repeat (4) pending_elements.push_back(16'sh7fff);
    repeat (4) pending_elements.push_back(16'sh8000);
    pending_elements.push_back(16'sh0000);
    pending_elements.push_back(16'shffff);
    pending_elements.push_back(16'sh0001);
    pending_elements.push_back(16'sh5555);
    pending_elements.push_back(16'shaaaa);
    pending_elements.push_back(16'sh7fff);
    pending_elements.push_back(16'sh8000);
    pending_elements.push_back(16'shffff);
    settle();

    // size zero behaves as a 1 by 1 matrix
    set_size(5'd0);
    pending_elements.push_back(16'sh7fff);
    pending_elements.push_back(16'sh8000);
    pending_elements.push_back(16'shffff);
    settle();

    set_size(5'd2);
    repeat (4) pending_elements.push_back(16'sh8000);
    settle();

    // random sizes, mostly whole matrices, some cut off mid-way
    while (small_items < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0: sz = 0;
        1: sz = $urandom_range(6, 9);
        default: sz = $urandom_range(1, 5);
      endcase
      set_size(SIZE_W'(sz));
      idle_on = ($urandom_range(0, 3) != 0);
      n   = eff_size(SIZE_W'(sz));
      cnt = n * n * ((n <= 5) ? $urandom_range(1, 3) : 1);
      if ($urandom_range(0, 4) == 0) cnt = $urandom_range(1, n * n + n);
      if (small_items + cnt > RANDOM_ITEMS) cnt = RANDOM_ITEMS - small_items;
      queue_elements(cnt);
      small_items += cnt;
      settle();
    end
    idle_on = 1'b1;
    if (row_at != 0 || col_at != 0) begin
      queue_elements(items_to_finish());
      settle();
    end

    // shrink the size after two rows of a 16 wide matrix
    set_size(5'd16);
    queue_elements(32);
    settle();
    set_size(5'd3);
    queue_elements(items_to_finish());
    settle();

    // long receiver hold-off while elements keep coming
    set_size(5'd4);
    want_long_hold <= 1'b1;
    queue_elements(32);
    settle();

    // oversized setting clamps to the largest matrix
    set_size(5'd31);
    queue_elements(256);
    settle();

    // closing stretch at full rate on both sides
    set_size(5'd5);
    idle_on = 1'b0;
    queue_elements(25);
    settle();
    repeat (20) @(posedge clk);

    if (sums_due.size() != 0) $error("%0d line sums never arrived", sums_due.size());
    $display("%0d elements in, %0d line sums checked, %0d size writes", elements_in,
             results_seen, size_writes);
    $display("sizes 0 to 31 incl. clamping, mid-matrix resize, long output stall");
    if (failures == 0 && sums_due.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
